[rtl/core/alpha_unblend_pixel_defines.svh]
// assertion macros used by the alpha unblend pixel pipeline control
`ifndef ALPHA_UNBLEND_PIXEL_DEFINES_SVH
`define ALPHA_UNBLEND_PIXEL_DEFINES_SVH

// clocked check, off while reset is asserted
`define AUP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define AUP_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/aup_pkg.sv]
// shared types and constants for the alpha unblend pixel block
`timescale 1ns / 1ps

package aup_pkg;

    localparam int NUM_LANES = 3;
    localparam int PIX_W     = 8;
    localparam int QUOT_W    = 8;
    localparam int DIV_STEPS = QUOT_W;

    // pipeline stage numbers
    localparam int STG_CAPTURE = 0;
    localparam int STG_PRODUCT = 1;
    localparam int STG_PREP    = 2;
    localparam int STG_DIV0    = 3;
    localparam int STG_MERGE   = STG_DIV0 + DIV_STEPS;
    localparam int PIPE_DEPTH  = STG_MERGE + 1;
    localparam int INFL_W      = $clog2(PIPE_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE  = 1'b1;

    localparam logic MODE_UNBLEND = 1'b0;
    localparam logic MODE_BLEND   = 1'b1;

    localparam logic [PIX_W-1:0] LEVEL_RESET   = 8'd255;
    localparam logic [PIX_W-1:0] NEAR_CODE_MIN = 8'd253;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_NEAR,
        KIND_DIV
    } t_kind;

    typedef struct packed {
        logic [PIPE_DEPTH-1:0] en;
        logic [PIPE_DEPTH-1:0] valid;
    } t_pipe_ctl;

endpackage

[rtl/core/aup_if.sv]
// handshake channels of the alpha unblend pixel block
`timescale 1ns / 1ps

interface aup_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] opacity_code;

    modport source (output valid, pixel_red, pixel_green, pixel_blue, opacity_code,
                    input ready);
    modport sink (input valid, pixel_red, pixel_green, pixel_blue, opacity_code,
                  output ready);
endinterface

interface aup_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface aup_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [aup_pkg::CFG_IDX_W-1:0]  index;
    logic [7:0]                     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/aup_cfg_regs.sv]
// configuration registers: overlay level and blend mode
`timescale 1ns / 1ps

module aup_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    aup_cfg_if.sink         i_cfg,
    output logic [7:0]      o_level,
    output logic            o_mode
);

    logic [7:0] r_level;
    logic       r_mode;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= aup_pkg::LEVEL_RESET;
            r_mode  <= aup_pkg::MODE_UNBLEND;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                aup_pkg::CFG_IDX_LEVEL: begin
                    r_level <= i_cfg.data;
                end
                aup_pkg::CFG_IDX_MODE: begin
                    r_mode <= i_cfg.data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_level = r_level;
    assign o_mode  = r_mode;

endmodule

[rtl/core/aup_pipe_ctrl.sv]
// stage valid tracking and per-stage load enables for the lane pipeline
`timescale 1ns / 1ps
`include "alpha_unblend_pixel_defines.svh"

module aup_pipe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output aup_pkg::t_pipe_ctl  o_ctl
);

    localparam int DEPTH = aup_pkg::PIPE_DEPTH;
    localparam int CNT_W = aup_pkg::INFL_W;

    logic [DEPTH-1:0] r_v;
    logic [DEPTH-1:0] n_v;
    logic [DEPTH-1:0] w_en;
    logic [DEPTH:0]   w_rdy;
    logic [CNT_W-1:0] r_inflight;
    logic [CNT_W-1:0] n_inflight;
    logic             w_in_acc;
    logic             w_out_acc;

    // a stage can load when it is empty or its content moves on
    always_comb begin
        w_rdy[DEPTH] = i_out_ready;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
        w_en[0] = w_rdy[0] && i_in_valid;
        for (int k = 1; k < DEPTH; k++) begin
            w_en[k] = w_rdy[k] && r_v[k-1];
        end
        for (int k = 0; k < DEPTH; k++) begin
            n_v[k] = w_en[k] || (r_v[k] && !w_rdy[k+1]);
        end
    end

    assign w_in_acc   = w_en[0];
    assign w_out_acc  = r_v[DEPTH-1] && i_out_ready;
    assign n_inflight = r_inflight + CNT_W'(w_in_acc) - CNT_W'(w_out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v        <= '0;
            r_inflight <= '0;
        end else begin
            r_v        <= n_v;
            r_inflight <= n_inflight;
        end
    end

    assign o_in_ready = w_rdy[0];
    assign o_ctl.en    = w_en;
    assign o_ctl.valid = r_v;

    `AUP_ASSERT(a_occupancy, i_clk, i_rst_n, $countones(r_v) == int'(r_inflight), "stage valids disagree with beats in flight")
    `AUP_ASSERT(a_block_only_full, i_clk, i_rst_n, !w_rdy[0] |-> (&r_v), "input blocked with a bubble in the pipeline")
    `AUP_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> ((r_v == '0) && (r_inflight == '0)), "pipeline not empty after reset")

endmodule

[rtl/core/aup_lane.sv]
// one color channel: product, range handling and an 8-stage restoring divider
`timescale 1ns / 1ps

module aup_lane (
    input  logic                i_clk,
    input  aup_pkg::t_pipe_ctl  i_ctl,
    input  logic [7:0]          i_pixel,
    input  logic [7:0]          i_code,
    input  logic [7:0]          i_level,
    input  logic                i_mode,
    output logic [7:0]          o_quot,
    output logic [7:0]          o_alt,
    output logic                o_use_div
);

    localparam int STEPS = aup_pkg::DIV_STEPS;
    localparam int QW    = aup_pkg::QUOT_W;

    // capture stage
    logic [7:0] r_p0;
    logic [7:0] r_a0;
    logic [7:0] r_l0;
    logic       r_m0;

    // product stage
    logic signed [9:0]  w_x;
    logic signed [18:0] w_prod;
    logic        [17:0] w_p255;
    logic signed [17:0] w_num;
    logic        [15:0] w_near_u;
    logic        [8:0]  w_den;
    aup_pkg::t_kind     w_kind;

    logic signed [17:0] r_num1;
    logic signed [15:0] r_near1;
    logic        [7:0]  r_p1;
    logic        [8:0]  r_den1;
    aup_pkg::t_kind     r_kind1;

    // prep stage
    logic [16:0] w_n2;
    logic [16:0] w_lim;
    logic [7:0]  w_alt;
    logic        w_use;

    // divider stages
    logic [16:0]   r_rem [STEPS];
    logic [8:0]    r_den [STEPS];
    logic [QW-1:0] r_q   [STEPS+1];
    logic [7:0]    r_alt [STEPS+1];
    logic          r_use [STEPS+1];
    logic [16:0]   w_shift [STEPS];
    logic          w_ge    [STEPS];
    logic [16:0]   w_rem_n [STEPS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[aup_pkg::STG_CAPTURE]) begin
            r_p0 <= i_pixel;
            r_a0 <= i_code;
            r_l0 <= i_level;
            r_m0 <= i_mode;
        end
    end

    // num = 255*p + a*x, x = L-p in blend mode and -L in unblend mode
    always_comb begin
        if (r_m0 == aup_pkg::MODE_BLEND) begin
            w_x = $signed({2'b00, r_l0}) - $signed({2'b00, r_p0});
        end else begin
            w_x = -$signed({2'b00, r_l0});
        end
        w_prod   = $signed({1'b0, r_a0}) * w_x;
        w_p255   = {2'b00, r_p0, 8'h00} - {10'b0, r_p0};
        w_num    = $signed(w_p255) + $signed(w_prod[17:0]);
        w_near_u = 16'(r_p0) * 16'd100 - 16'(r_l0) * 16'd99;
        if (r_m0 == aup_pkg::MODE_BLEND) begin
            w_den = 9'd510;
        end else begin
            w_den = {8'd255 - r_a0, 1'b0};
        end
        if (r_a0 == 8'd0) begin
            w_kind = aup_pkg::KIND_PASS;
        end else if ((r_m0 == aup_pkg::MODE_UNBLEND) && (r_a0 >= aup_pkg::NEAR_CODE_MIN)) begin
            w_kind = aup_pkg::KIND_NEAR;
        end else begin
            w_kind = aup_pkg::KIND_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[aup_pkg::STG_PRODUCT]) begin
            r_num1  <= w_num;
            r_near1 <= $signed(w_near_u);
            r_p1    <= r_p0;
            r_den1  <= w_den;
            r_kind1 <= w_kind;
        end
    end

    // rounded dividend 2*num + den/2, saturation test against 256*den
    always_comb begin
        w_n2  = {r_num1[15:0], 1'b0} + {9'b0, r_den1[8:1]};
        w_lim = {r_den1, 8'h00};
        w_alt = 8'h00;
        w_use = 1'b0;
        case (r_kind1)
            aup_pkg::KIND_PASS: begin
                w_alt = r_p1;
            end
            aup_pkg::KIND_NEAR: begin
                if (r_near1 < 16'sd0) begin
                    w_alt = 8'h00;
                end else if (r_near1 > 16'sd255) begin
                    w_alt = 8'hFF;
                end else begin
                    w_alt = r_near1[7:0];
                end
            end
            aup_pkg::KIND_DIV: begin
                if (r_num1 <= 18'sd0) begin
                    w_alt = 8'h00;
                end else if (w_n2 >= w_lim) begin
                    w_alt = 8'hFF;
                end else begin
                    w_use = 1'b1;
                end
            end
            default: begin
                w_alt = 8'h00;
            end
        endcase
    end

    // one quotient bit per stage, msb first
    always_comb begin
        for (int j = 0; j < STEPS; j++) begin
            w_shift[j] = {8'b0, r_den[j]} << (STEPS - 1 - j);
            w_ge[j]    = r_rem[j] >= w_shift[j];
            w_rem_n[j] = w_ge[j] ? (r_rem[j] - w_shift[j]) : r_rem[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[aup_pkg::STG_PREP]) begin
            r_rem[0] <= w_n2;
            r_den[0] <= r_den1;
            r_q[0]   <= '0;
            r_alt[0] <= w_alt;
            r_use[0] <= w_use;
        end
        for (int j = 0; j < STEPS; j++) begin
            if (i_ctl.en[aup_pkg::STG_DIV0 + j]) begin
                r_q[j+1]   <= {r_q[j][QW-2:0], w_ge[j]};
                r_alt[j+1] <= r_alt[j];
                r_use[j+1] <= r_use[j];
            end
        end
        for (int j = 1; j < STEPS; j++) begin
            if (i_ctl.en[aup_pkg::STG_DIV0 + j - 1]) begin
                r_rem[j] <= w_rem_n[j-1];
                r_den[j] <= r_den[j-1];
            end
        end
    end

    assign o_quot    = r_q[STEPS];
    assign o_alt     = r_alt[STEPS];
    assign o_use_div = r_use[STEPS];

endmodule

[rtl/core/alpha_unblend_pixel.sv]
// top level of the alpha unblend pixel block: lanes, control and output merge
// Removes (unblend) or applies (blend) a constant-level overlay on one RGB pixel per
// beat, with opacity alpha = opacity_code/255 and overlay level L from register 0;
// register 1 selects blend (1) or unblend (0). Unblend gives round((255*p - a*L)/(255-a)),
// codes 253..255 use 100*p - 99*L, blend gives round((a*L + (255-a)*p)/255); results
// saturate to 0..255 and a code of 0 passes the pixel through. Throughput is one pixel
// per clock while the output side does not stall. Each channel runs through a pipeline
// of capture, one multiply stage, a range/rounding stage, an 8-stage restoring divider
// (one quotient bit per stage) and the output merge register. Bubbles collapse, so input
// keeps being taken while a finished pixel waits, until all 12 stages are full.
// Configuration is sampled with each pixel as it enters; the config channel is always
// ready.
`timescale 1ns / 1ps

module alpha_unblend_pixel (
    input  logic            i_clk,
    input  logic            i_rst_n,
    aup_pix_in_if.sink      i_pix,
    aup_pix_out_if.source   o_pix,
    aup_cfg_if.sink         i_cfg
);

    localparam int LANES = aup_pkg::NUM_LANES;

    aup_pkg::t_pipe_ctl w_ctl;
    logic               w_in_ready;
    logic [7:0]         w_level;
    logic               w_mode;

    // per-channel pixel values and lane results
    logic [7:0]       w_pix  [LANES];
    logic [7:0]       w_quot [LANES];
    logic [7:0]       w_alt  [LANES];
    logic [LANES-1:0] w_use;
    logic [7:0]       r_out  [LANES];

    aup_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_level (w_level),
        .o_mode  (w_mode)
    );

    // valid per stage, load enables, back-pressure toward the input
    aup_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_out_ready (o_pix.ready),
        .o_in_ready  (w_in_ready),
        .o_ctl       (w_ctl)
    );

    assign i_pix.ready = w_in_ready;

    // lane order is red, green, blue
    assign w_pix[0] = i_pix.pixel_red;
    assign w_pix[1] = i_pix.pixel_green;
    assign w_pix[2] = i_pix.pixel_blue;

    for (genvar c = 0; c < LANES; c++) begin : g_lane
        aup_lane u_lane (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_pixel   (w_pix[c]),
            .i_code    (i_pix.opacity_code),
            .i_level   (w_level),
            .i_mode    (w_mode),
            .o_quot    (w_quot[c]),
            .o_alt     (w_alt[c]),
            .o_use_div (w_use[c])
        );
    end

    // merge: each lane hands over either its quotient or a direct value
    always_ff @(posedge i_clk) begin
        if (w_ctl.en[aup_pkg::STG_MERGE]) begin
            for (int c = 0; c < LANES; c++) begin
                r_out[c] <= w_use[c] ? w_quot[c] : w_alt[c];
            end
        end
    end

    assign o_pix.valid     = w_ctl.valid[aup_pkg::STG_MERGE];
    assign o_pix.out_red   = r_out[0];
    assign o_pix.out_green = r_out[1];
    assign o_pix.out_blue  = r_out[2];

endmodule
